### design/fbfl_pkg.sv
// package for the fixed block free list allocator
// operation and status codes, controller states, controller command struct
// no dependencies
package fbfl_pkg;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam int          IDX_W         = 8;
    localparam int          CNT_W         = 9;
    localparam logic [8:0]  ACTIVE_RESET  = 9'd256;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

endpackage

### design/fixed_block_free_list_allocator_unit.sv
// fixed block free list allocator, top level
// link memory read at the input transfer; list update and result registered at the execute step
// one item in flight; execute waits for an earlier result to be taken
// clear relinks in its execute step through per-entry relink flags; no clearing pass
// reset: synchronous active low; list linked over all blocks, active_blocks 256
// depends on fbfl_pkg, fbfl_ctrl, fbfl_datapath
module fixed_block_free_list_allocator_unit import fbfl_pkg::*; #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_mode,
    input  logic [IDX_W-1:0] i_block_index,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [IDX_W-1:0] o_granted_index,
    output logic [1:0]       o_status,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data
);

    localparam int DEPTH = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;

    t_dp_cmd w_cmd;

    fbfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    fbfl_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_mode          (i_mode),
        .i_block_index   (i_block_index),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_granted_index (o_granted_index),
        .o_status        (o_status)
    );

    // one item in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input transfer taken while an item is in flight");

    // a failed or ignored operation grants nothing
    a_fail_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_granted_index == '0))
        else $error("nonzero grant with error status");

    // a new result only follows an execute step
    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.execute))
        else $error("result appeared without an execute step");

    // capture and execute never coincide
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.capture && w_cmd.execute))
        else $error("capture and execute in the same cycle");

endmodule

### design/fbfl_ctrl.sv
// controller for the free list allocator
// sequences capture and execute, owns the result handshake
// depends on fbfl_pkg
module fbfl_ctrl import fbfl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_exec;

    assign w_accept = (r_state == S_IDLE) && i_in_valid;
    assign w_exec   = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_exec) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == S_IDLE);
        o_cmd.capture = w_accept;
        o_cmd.execute = w_exec;
        if (w_exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### design/fbfl_datapath.sv
// datapath for the free list allocator
// link memory, relink flags, list head, block count and result registers
// depends on fbfl_pkg
module fbfl_datapath import fbfl_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [1:0]       i_mode,
    input  logic [IDX_W-1:0] i_block_index,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    output logic [IDX_W-1:0] o_granted_index,
    output logic [1:0]       o_status
);

    localparam int              AW      = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_N = CNT_W'(DEPTH);

    logic [CNT_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_dflt;
    logic [CNT_W-1:0] r_active;
    logic [CNT_W-1:0] r_link_n;
    logic [CNT_W-1:0] n_link_n;
    logic [IDX_W-1:0] r_head;
    logic [IDX_W-1:0] n_head;
    logic             r_head_valid;
    logic             n_head_valid;
    logic [CNT_W-1:0] r_rd_data;
    logic             r_rd_dflt;
    logic [1:0]       r_mode;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_granted;
    logic [IDX_W-1:0] n_granted;
    logic [1:0]       r_status;
    logic [1:0]       n_status;

    logic [CNT_W-1:0] w_eff;
    logic             w_head_in_range;
    logic [AW-1:0]    w_rd_addr;
    logic [AW-1:0]    w_wr_addr;
    logic             w_dflt_valid;
    logic [CNT_W-1:0] w_link;
    logic             w_mem_we;
    logic             w_relink;

    assign w_eff           = (r_active > DEPTH_N) ? DEPTH_N : r_active;
    assign w_head_in_range = ({1'b0, r_head} < DEPTH_N);
    assign w_rd_addr       = r_head[AW-1:0];
    assign w_wr_addr       = r_idx[AW-1:0];
    assign w_dflt_valid    = (({1'b0, r_head} + 9'd1) < r_link_n);
    assign w_link          = r_rd_dflt ? {w_dflt_valid, r_head + 8'd1} : r_rd_data;

    always_comb begin
        n_head       = r_head;
        n_head_valid = r_head_valid;
        n_link_n     = r_link_n;
        n_granted    = '0;
        n_status     = ST_OK;
        w_mem_we     = 1'b0;
        w_relink     = 1'b0;
        case (r_mode)
            MODE_ALLOC: begin
                if (!r_head_valid) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_granted = r_head;
                    if (w_head_in_range) begin
                        n_head_valid = w_link[CNT_W-1];
                        n_head       = w_link[IDX_W-1:0];
                    end else begin
                        n_head_valid = 1'b0;
                        n_head       = '0;
                    end
                end
            end
            MODE_FREE: begin
                if ({1'b0, r_idx} >= w_eff) begin
                    n_status = ST_RANGE;
                end else begin
                    w_mem_we     = i_cmd.execute;
                    n_head       = r_idx;
                    n_head_valid = 1'b1;
                end
            end
            MODE_CLEAR: begin
                w_relink     = i_cmd.execute;
                n_link_n     = w_eff;
                n_head       = '0;
                n_head_valid = (w_eff != '0);
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // link memory, registered read of the head entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= {r_head_valid, r_head};
        end
    end

    // entry reads as its relinked value until written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dflt <= '1;
        end else if (w_relink) begin
            r_dflt <= '1;
        end else if (w_mem_we) begin
            r_dflt[w_wr_addr] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_dflt <= r_dflt[w_rd_addr];
            r_mode    <= i_mode;
            r_idx     <= i_block_index;
        end
        if (i_cmd.execute) begin
            r_granted <= n_granted;
            r_status  <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= ACTIVE_RESET;
            r_link_n     <= DEPTH_N;
            r_head       <= '0;
            r_head_valid <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
            if (i_cmd.execute) begin
                r_head       <= n_head;
                r_head_valid <= n_head_valid;
                r_link_n     <= n_link_n;
            end
        end
    end

    assign o_granted_index = r_granted;
    assign o_status        = r_status;

endmodule

### verif/fbfl_pool_checker.sv
`timescale 1ns / 1ps
// result checker for the fixed block free list allocator: predicts the grant and status
// of every input transfer from its own copy of the free list and compares result transfers
// depends on fbfl_pkg
module fbfl_pool_checker import fbfl_pkg::*; #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [1:0]       i_mode,
    input  logic [IDX_W-1:0] i_block_index,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [IDX_W-1:0] i_granted_index,
    input  logic [1:0]       i_status,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    output int               o_mismatches,
    output int               o_pending
);

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [1:0]       status;
    } t_grant;

    logic [IDX_W-1:0] link_next [MAX_BLOCKS];
    logic             link_ok   [MAX_BLOCKS];
    logic [IDX_W-1:0] head_at;
    logic             head_ok;
    logic [CNT_W-1:0] active_count;
    t_grant           expected_grants [$];
    t_grant           oldest;
    int               mismatch_count = 0;
    int               pending_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    function automatic int usable_blocks();
        int n;
        n = int'(active_count);
        if (n > MAX_BLOCKS) n = MAX_BLOCKS;
        if (n > 256) n = 256;
        return n;
    endfunction

    function automatic void relink_pool();
        int n;
        n = usable_blocks();
        head_at = '0;
        head_ok = 1'b0;
        if (n != 0) begin
            for (int i = 0; i + 1 < n; i++) begin
                link_next[i] = IDX_W'(i + 1);
                link_ok[i]   = 1'b1;
            end
            link_next[n - 1] = '0;
            link_ok[n - 1]   = 1'b0;
            head_ok = 1'b1;
        end
    endfunction

    function automatic t_grant apply_pool_op(logic [1:0] op, logic [IDX_W-1:0] idx);
        t_grant           r;
        logic [IDX_W-1:0] h;
        r.index  = '0;
        r.status = ST_OK;
        if (op == MODE_ALLOC) begin
            if (!head_ok) begin
                r.status = ST_EMPTY;
            end else begin
                h       = head_at;
                r.index = h;
                head_ok = link_ok[h];
                head_at = link_next[h];
            end
        end else if (op == MODE_FREE) begin
            if (int'(idx) >= usable_blocks()) begin
                r.status = ST_RANGE;
            end else begin
                link_next[idx] = head_at;
                link_ok[idx]   = head_ok;
                head_at        = idx;
                head_ok        = 1'b1;
            end
        end else if (op == MODE_CLEAR) begin
            relink_pool();
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            active_count = ACTIVE_RESET;
            for (int i = 0; i < MAX_BLOCKS; i++) begin
                link_next[i] = '0;
                link_ok[i]   = 1'b0;
            end
            relink_pool();
            expected_grants.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_grants.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, got index %0d status %0d",
                             $time, i_granted_index, i_status);
                    mismatch_count++;
                end else begin
                    oldest = expected_grants.pop_front();
                    if (i_granted_index !== oldest.index) begin
                        $display("%0t: granted_index expected %0d, got %0d",
                                 $time, oldest.index, i_granted_index);
                        mismatch_count++;
                    end
                    if (i_status !== oldest.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, oldest.status, i_status);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_grants.push_back(apply_pool_op(i_mode, i_block_index));
            if (i_cfg_we)
                active_count = i_cfg_data;
        end
        pending_count <= expected_grants.size();
    end

endmodule

### verif/fixed_block_free_list_allocator_unit_tb.sv
`timescale 1ns / 1ps
// testbench top for the fixed block free list allocator: clock, reset, stimulus and verdict
// depends on fbfl_pkg, fixed_block_free_list_allocator_unit and fbfl_pool_checker
module fixed_block_free_list_allocator_unit_tb;
    import fbfl_pkg::*;

    localparam int         BLOCKS       = 256;
    localparam int         RANDOM_ITEMS = 800;
    localparam int         LONG_HOLD    = 300;
    localparam int         CYCLE_LIMIT  = 500000;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [1:0]       mode = MODE_ALLOC;
    logic [IDX_W-1:0] block_index = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [IDX_W-1:0] granted_index;
    logic [1:0]       status;
    logic             cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_data = '0;
    int               mismatches;
    int               pending;
    int               hold_requests = 0;
    bit               sender_gaps = 1'b1;

    fixed_block_free_list_allocator_unit #(
        .MAX_BLOCKS(BLOCKS)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_mode         (mode),
        .i_block_index  (block_index),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_granted_index(granted_index),
        .o_status       (status),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data)
    );

    fbfl_pool_checker #(
        .MAX_BLOCKS(BLOCKS)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_mode         (mode),
        .i_block_index  (block_index),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_granted_index(granted_index),
        .i_status       (status),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #(CYCLE_LIMIT * 20);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_op(input logic [1:0] op, input logic [IDX_W-1:0] idx);
        int gap;
        gap = sender_gaps ? gap_len() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= op;
        block_index <= idx;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_active(input logic [CNT_W-1:0] count);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= count;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_op(input int usable, input int alloc_pct);
        int               pick;
        int               sel;
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(0, 99);
        idx  = IDX_W'($urandom_range(0, 255));
        if (pick < alloc_pct) begin
            op = MODE_ALLOC;
        end else if (pick < 94) begin
            op  = MODE_FREE;
            sel = $urandom_range(0, 99);
            if (sel < 75 && usable > 0)
                idx = IDX_W'($urandom_range(0, usable - 1));
            else if (sel < 90)
                idx = IDX_W'(usable + $urandom_range(0, 3));
        end else if (pick < 97) begin
            op = MODE_CLEAR;
        end else begin
            op = MODE_NONE;
        end
        send_op(op, idx);
    endtask

    // result side: random stalls, calm stretches, and a long hold on request
    initial begin
        int stall_left;
        int calm_left;
        int holds_seen;
        stall_left = 0;
        calm_left  = 0;
        holds_seen = 0;
        forever begin
            @(posedge clk);
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 9) == 0)
                    calm_left = $urandom_range(20, 100);
                else
                    stall_left = gap_len();
            end
        end
    end

    initial begin
        logic [CNT_W-1:0] count;
        int               usable;
        int               phase_len;
        int               alloc_pct;
        int               sent;
        int               pick;
        sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full pool after reset, top index, unused mode
        send_op(MODE_ALLOC, 8'hff);
        send_op(MODE_FREE, 8'd255);
        send_op(MODE_ALLOC, 8'h00);
        send_op(MODE_NONE, 8'ha5);

        // count shrunk without clear, then clear on two blocks
        write_active(9'd2);
        send_op(MODE_ALLOC, 8'h00);
        send_op(MODE_ALLOC, 8'h00);
        send_op(MODE_FREE, 8'd2);
        send_op(MODE_FREE, 8'd1);
        send_op(MODE_CLEAR, 8'h5a);
        send_op(MODE_ALLOC, 8'h00);
        send_op(MODE_ALLOC, 8'h00);
        send_op(MODE_ALLOC, 8'h00);

        // zero count
        write_active(9'd0);
        send_op(MODE_CLEAR, 8'h00);
        send_op(MODE_ALLOC, 8'h00);
        send_op(MODE_FREE, 8'd0);

        // count above the index reach
        write_active(9'd511);
        send_op(MODE_CLEAR, 8'h00);
        send_op(MODE_FREE, 8'd255);
        send_op(MODE_ALLOC, 8'h00);

        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 13);
            case (pick)
                0:       count = 9'd1;
                1:       count = 9'd2;
                2:       count = 9'd3;
                3:       count = 9'd4;
                4:       count = 9'd8;
                5:       count = 9'd16;
                6:       count = 9'd100;
                7:       count = 9'd255;
                8:       count = 9'd256;
                9:       count = 9'd257;
                10:      count = 9'd511;
                11:      count = 9'd0;
                12:      count = CNT_W'($urandom_range(1, 256));
                default: count = CNT_W'($urandom_range(0, 511));
            endcase
            usable      = (count > 9'd256) ? 256 : int'(count);
            write_active(count);
            sender_gaps = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 85)
                send_op(MODE_CLEAR, IDX_W'($urandom_range(0, 255)));
            phase_len = $urandom_range(30, 120);
            alloc_pct = $urandom_range(30, 70);
            repeat (phase_len) begin
                if (sent == 50)
                    hold_requests++;
                random_op(usable, alloc_pct);
                sent++;
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
